### rtl/core/largest_rect_in_rotated_rect_core_macros.svh
// Assertion macros for the checker file of the rotated-rectangle core.
// The macros expect a signal named clk in the scope that uses them; LRR_ASSERT also expects rst.
`ifndef LARGEST_RECT_IN_ROTATED_RECT_CORE_MACROS_SVH
`define LARGEST_RECT_IN_ROTATED_RECT_CORE_MACROS_SVH

// Checked only outside reset.
`define LRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define LRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lrr_pkg.sv
// Package of the rotated-rectangle core: default parameters, angle constants
// and the CORDIC start value. Used by largest_rect_in_rotated_rect_core.
package lrr_pkg;

  localparam int DEF_FRAC_BITS       = 8;
  localparam int DEF_DIM_BITS        = 13;
  localparam int DEF_TRIG_ITERATIONS = 16;

  localparam int ANG_Q     = 30;
  localparam int TABLE_LEN = 24;

  // atan(2^-i) in Q30, rounded; entry zero is atan(1).
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  localparam logic [34:0] PI_Q      = 35'd3373259428;
  localparam logic [34:0] HALF_PI_Q = 35'd1686629714;

  // Start value of x in Q30: the inverse CORDIC gain for n iterations, rounded.
  function automatic logic [63:0] cordic_x0(input int n);
    logic [63:0] gain;
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int i;
    gain = 64'h1 << 60;
    for (i = 0; i < n; i++) begin
      gain = gain + (gain >> (2 * i));
    end
    res = '0;
    bv = 64'h1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bv > gain) begin
        bv = bv >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bv != 0) begin
        if (gain >= res + bv) begin
          gain = gain - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    num = (64'h1 << 60) + (res >> 1);
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= res) begin
        rem = rem - res;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

### rtl/core/largest_rect_in_rotated_rect_core.sv
// Largest axis-aligned rectangle inside a rotated image: takes width, height
// and a Q3.13 angle and gives the inscribed width and height in unsigned
// Q(DIM_BITS).(FRAC_BITS). One transaction enters per cycle while in_ready
// is high. The pipeline has one CORDIC stage per iteration and one quotient
// bit per stage in the two dividers. Stages that hold no valid item keep
// taking new input while a finished result waits at the output.
module largest_rect_in_rotated_rect_core #(
  parameter int FRAC_BITS       = lrr_pkg::DEF_FRAC_BITS,
  parameter int DIM_BITS        = lrr_pkg::DEF_DIM_BITS,
  parameter int TRIG_ITERATIONS = lrr_pkg::DEF_TRIG_ITERATIONS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [DIM_BITS-1:0]           in_width,
  input  logic [DIM_BITS-1:0]           in_height,
  input  logic signed [15:0]            angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DIM_BITS+FRAC_BITS-1:0] out_width,
  output logic [DIM_BITS+FRAC_BITS-1:0] out_height,
  output logic                          size_error
);

  localparam int DW = DIM_BITS;
  localparam int FW = FRAC_BITS;
  localparam int OW = DW + FW;
  localparam int NW = OW + 31;
  localparam int TW = DW + 33;
  localparam int XW = 34;
  localparam int ZW = 35;
  localparam int NI = (TRIG_ITERATIONS < lrr_pkg::TABLE_LEN) ?
                      TRIG_ITERATIONS : lrr_pkg::TABLE_LEN;
  localparam int S_CL  = NI + 1;
  localparam int S_MU  = NI + 2;
  localparam int S_TS  = NI + 3;
  localparam int S_SEL = NI + 4;
  localparam int S_DV  = NI + 5;
  localparam int L     = NI + 5 + OW;
  localparam logic [63:0] X0_FULL = lrr_pkg::cordic_x0(NI);
  localparam logic [XW-1:0] ONE_X = XW'(64'h1 << lrr_pkg::ANG_Q);
  localparam logic [OW-1:0] OUT_MAX = '1;

  function automatic logic [30:0] clamp_unit(input logic signed [XW-1:0] v);
    logic [XW-1:0] m;
    m = v[XW-1] ? XW'(-v) : XW'(v);
    return (m > ONE_X) ? ONE_X[30:0] : m[30:0];
  endfunction

  logic [L:0] v;
  logic [L:0] en;

  always_comb begin
    en[L] = !v[L] || out_ready;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k <= L; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  logic [16:0]          ang_mag;
  logic signed [ZW-1:0] a_lin;
  logic signed [ZW-1:0] a_fold;
  logic signed [ZW-1:0] a_in;

  always_comb begin
    ang_mag = angle[15] ? (17'd0 - {angle[15], angle}) : {1'b0, angle};
    a_lin   = signed'({1'b0, ang_mag, 17'b0});
    a_fold  = signed'(lrr_pkg::PI_Q) - a_lin;
    if (a_lin > signed'(lrr_pkg::HALF_PI_Q)) begin
      a_in = a_fold[ZW-1] ? -a_fold : a_fold;
    end else begin
      a_in = a_lin;
    end
  end

  logic signed [XW-1:0] cx [0:NI];
  logic signed [XW-1:0] cy [0:NI];
  logic signed [ZW-1:0] cz [0:NI];
  logic [DW-1:0]        cw [0:NI];
  logic [DW-1:0]        ch [0:NI];
  logic                 ce [0:NI];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cx[0] <= signed'(X0_FULL[XW-1:0]);
      cy[0] <= '0;
      cz[0] <= a_in;
      cw[0] <= in_width;
      ch[0] <= in_height;
      ce[0] <= (in_width == '0) || (in_height == '0);
    end
  end

  for (genvar j = 1; j <= NI; j++) begin : g_cordic
    localparam logic signed [ZW-1:0] TAB_J = signed'(ZW'(lrr_pkg::ATAN_TAB[j-1]));
    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (!cz[j-1][ZW-1]) begin
          cx[j] <= cx[j-1] - (cy[j-1] >>> (j - 1));
          cy[j] <= cy[j-1] + (cx[j-1] >>> (j - 1));
          cz[j] <= cz[j-1] - TAB_J;
        end else begin
          cx[j] <= cx[j-1] + (cy[j-1] >>> (j - 1));
          cy[j] <= cy[j-1] - (cx[j-1] >>> (j - 1));
          cz[j] <= cz[j-1] + TAB_J;
        end
        cw[j] <= cw[j-1];
        ch[j] <= ch[j-1];
        ce[j] <= ce[j-1];
      end
    end
  end

  logic [30:0]   s1, c1;
  logic [DW-1:0] w1, h1, lng1, sht1;
  logic          wide1, e1;

  always_ff @(posedge clk) begin
    if (en[S_CL]) begin
      s1    <= clamp_unit(cy[NI]);
      c1    <= clamp_unit(cx[NI]);
      w1    <= cw[NI];
      h1    <= ch[NI];
      wide1 <= cw[NI] > ch[NI];
      lng1  <= (cw[NI] > ch[NI]) ? cw[NI] : ch[NI];
      sht1  <= (cw[NI] > ch[NI]) ? ch[NI] : cw[NI];
      e1    <= ce[NI];
    end
  end

  logic [61:0]    sc2, cc2, ss2;
  logic [DW+30:0] wc2, hs2, hc2, ws2;
  logic [30:0]    s2, c2;
  logic [DW-1:0]  lng2, sht2;
  logic           wide2, e2;

  always_ff @(posedge clk) begin
    if (en[S_MU]) begin
      sc2   <= s1 * c1;
      cc2   <= c1 * c1;
      ss2   <= s1 * s1;
      wc2   <= w1 * c1;
      hs2   <= h1 * s1;
      hc2   <= h1 * c1;
      ws2   <= w1 * s1;
      s2    <= s1;
      c2    <= c1;
      lng2  <= lng1;
      sht2  <= sht1;
      wide2 <= wide1;
      e2    <= e1;
    end
  end

  logic [TW-1:0]        t3;
  logic signed [62:0]   d3;
  logic signed [DW+31:0] nw3, nh3;
  logic                 close3, wide3, e3;
  logic [30:0]          s3, c3;
  logic [DW-1:0]        sht3;

  always_ff @(posedge clk) begin
    if (en[S_TS]) begin
      t3     <= (TW'(sc2[61:30]) * TW'(lng2)) << 1;
      d3     <= signed'({1'b0, cc2}) - signed'({1'b0, ss2});
      nw3    <= signed'({1'b0, wc2}) - signed'({1'b0, hs2});
      nh3    <= signed'({1'b0, hc2}) - signed'({1'b0, ws2});
      close3 <= ((s2 > c2) ? (s2 - c2) : (c2 - s2)) <= 31'd1;
      s3     <= s2;
      c3     <= c2;
      sht3   <= sht2;
      wide3  <= wide2;
      e3     <= e2;
    end
  end

  logic                  half_sel;
  logic [62:0]           d_abs;
  logic [30:0]           d_mag;
  logic [NW-1:0]         half_num;
  logic [NW-1:0]         num_sel [2];
  logic [30:0]           den_sel [2];
  logic                  fz_sel  [2];
  logic                  fm_sel  [2];
  logic signed [DW+31:0] n_lane  [2];
  logic [DW+31:0]        n_abs   [2];

  always_comb begin
    half_sel = (TW'({sht3, 30'b0}) <= t3) || close3;
    d_abs    = d3[62] ? 63'(-d3) : 63'(d3);
    d_mag    = d_abs[60:30];
    half_num = NW'(sht3) << (29 + FW);
    n_lane[0] = nw3;
    n_lane[1] = nh3;
    for (int l = 0; l < 2; l++) begin
      n_abs[l] = n_lane[l][DW+31] ? (DW+32)'(-n_lane[l]) : (DW+32)'(n_lane[l]);
      if (half_sel) begin
        den_sel[l] = ((l == 0) == wide3) ? s3 : c3;
        num_sel[l] = half_num + NW'(den_sel[l] >> 1);
        fz_sel[l]  = 1'b0;
        fm_sel[l]  = den_sel[l] == '0;
      end else begin
        den_sel[l] = d_mag;
        num_sel[l] = (NW'(n_abs[l]) << FW) + NW'(d_mag >> 1);
        fz_sel[l]  = (n_lane[l] == '0) || (n_lane[l][DW+31] != d3[62]);
        fm_sel[l]  = d_mag == '0;
      end
    end
  end

  logic [NW-1:0] dr   [0:OW][2];
  logic [30:0]   dd   [0:OW][2];
  logic [OW-1:0] dq   [0:OW][2];
  logic          dsat [0:OW][2];
  logic          dfz  [0:OW][2];
  logic          dfm  [0:OW][2];
  logic          de   [0:OW];
  logic [NW-1:0] num4 [2];
  logic [30:0]   den4 [2];
  logic          fz4  [2];
  logic          fm4  [2];
  logic          e4;

  always_ff @(posedge clk) begin
    if (en[S_SEL]) begin
      num4 <= num_sel;
      den4 <= den_sel;
      fz4  <= fz_sel;
      fm4  <= fm_sel;
      e4   <= e3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_DV]) begin
      for (int l = 0; l < 2; l++) begin
        dr[0][l]   <= num4[l];
        dd[0][l]   <= den4[l];
        dq[0][l]   <= '0;
        dsat[0][l] <= num4[l] >= {den4[l], {OW{1'b0}}};
        dfz[0][l]  <= fz4[l];
        dfm[0][l]  <= fm4[l];
      end
      de[0] <= e4;
    end
  end

  for (genvar m = 1; m <= OW; m++) begin : g_div
    localparam int BI = OW - m;
    always_ff @(posedge clk) begin
      if (en[S_DV+m]) begin
        for (int l = 0; l < 2; l++) begin
          if (dr[m-1][l] >= (NW'(dd[m-1][l]) << BI)) begin
            dr[m][l] <= dr[m-1][l] - (NW'(dd[m-1][l]) << BI);
            dq[m][l] <= dq[m-1][l] | (OW'(1) << BI);
          end else begin
            dr[m][l] <= dr[m-1][l];
            dq[m][l] <= dq[m-1][l];
          end
          dd[m][l]   <= dd[m-1][l];
          dsat[m][l] <= dsat[m-1][l];
          dfz[m][l]  <= dfz[m-1][l];
          dfm[m][l]  <= dfm[m-1][l];
        end
        de[m] <= de[m-1];
      end
    end
  end

  logic [OW-1:0] res [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (de[OW]) begin
        res[l] = '0;
      end else if (dfm[OW][l]) begin
        res[l] = OUT_MAX;
      end else if (dfz[OW][l]) begin
        res[l] = '0;
      end else if (dsat[OW][l]) begin
        res[l] = OUT_MAX;
      end else begin
        res[l] = dq[OW][l];
      end
    end
  end

  assign out_valid  = v[L];
  assign out_width  = res[0];
  assign out_height = res[1];
  assign size_error = de[OW];

endmodule

### rtl/core/lrr_checker.sv
// Port-level checker for largest_rect_in_rotated_rect_core and its bind.
// Depends on largest_rect_in_rotated_rect_core_macros.svh.
`include "largest_rect_in_rotated_rect_core_macros.svh"

module lrr_checker #(
  parameter int OUT_BITS = lrr_pkg::DEF_DIM_BITS + lrr_pkg::DEF_FRAC_BITS
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] out_width,
  input logic [OUT_BITS-1:0] out_height,
  input logic                size_error
);

  `LRR_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "Output valid after reset.")
  `LRR_ASSERT(a_error_zero, out_valid && size_error |-> out_width == '0 && out_height == '0, "Size error with nonzero result.")
  `LRR_ASSERT(a_full_only, !in_ready |-> out_valid && !out_ready, "Input stalled while the output is free.")
  `LRR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_width) && $stable(out_height) && $stable(size_error), "Stalled result changed.")

endmodule

bind largest_rect_in_rotated_rect_core lrr_checker #(
  .OUT_BITS(DIM_BITS + FRAC_BITS)
) u_lrr_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_width(out_width),
  .out_height(out_height),
  .size_error(size_error)
);
